### rtl/core/udtc_pkg.sv
// Shared types and constants for the up/down digipot tap controller.
package udtc_pkg;

  localparam int TAP_BITS = 7;

  // Request kinds carried on s_tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Sequencer codes
  localparam logic [2:0] SEQ_IDLE      = 3'd0;
  localparam logic [2:0] SEQ_HOME_LOW  = 3'd1;
  localparam logic [2:0] SEQ_HOME_HIGH = 3'd2;
  localparam logic [2:0] SEQ_STEP_LOW  = 3'd3;
  localparam logic [2:0] SEQ_STEP_HIGH = 3'd4;
  localparam logic [2:0] SEQ_STEP_END  = 3'd5;
  localparam logic [2:0] SEQ_STORE_END = 3'd6;

  // Register indexes on the config port
  localparam logic REG_OUTPUT_ENABLED = 1'b0;
  localparam logic REG_MAX_TAP        = 1'b1;

  // Classified request as it sits in the queue
  typedef struct packed {
    logic                is_set;
    logic [TAP_BITS-1:0] target;
    logic                store;
  } item_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic                output_enabled;
    logic [TAP_BITS-1:0] max_tap;
    logic                oe_clear;   // pulse: output_enabled written to 0
  } cfg_t;

  // One result
  typedef struct packed {
    logic                rejected;
    logic                busy_res;
    logic                tap_known;
    logic [TAP_BITS-1:0] tap_now;
    logic                direction_level;
    logic                increment_level;
    logic                select_level;
  } result_t;

endpackage

### rtl/core/udtc_front.sv
// Front end: decodes incoming requests and clamps the target tap.
module udtc_front import udtc_pkg::*; (
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                s_tuser,    // [0] command
  input  logic [15:0]         s_tdata,    // [7:0] target_tap, [8] store_after
  input  logic [TAP_BITS-1:0] max_tap,
  input  logic                q_ready,
  output logic                q_push,
  output item_t               q_item
);

  logic [7:0] target_raw;
  logic [7:0] limit;

  assign target_raw = s_tdata[7:0];
  assign limit      = {1'b0, max_tap};

  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;

  always_comb begin
    q_item.is_set = (s_tuser == CMD_SET);
    q_item.store  = s_tdata[8];
    if (target_raw > limit) begin
      q_item.target = max_tap;
    end else begin
      q_item.target = target_raw[TAP_BITS-1:0];
    end
  end

endmodule

### rtl/core/udtc_queue.sv
// Two-entry queue between the front end and the sequencer.
module udtc_queue import udtc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2))
    else $error("queue lost a request while full");

endmodule

### rtl/core/udtc_back.sv
// Back end: pin waveform sequencer and registered result stage.
module udtc_back import udtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_head,
  output logic    q_pop,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t m_result
);

  logic [TAP_BITS-1:0] tap, tap_next;
  logic                known, known_next;
  logic [TAP_BITS-1:0] target, target_next;
  logic [2:0]          state, state_next;
  logic [TAP_BITS-1:0] hcount, hcount_next;
  logic                store_pend, store_pend_next;
  logic                sel, sel_next;
  logic                inc, inc_next;
  logic                dir, dir_next;
  logic                rej;
  logic                out_valid;
  result_t             out_data;

  assign q_pop    = q_valid && (!out_valid || m_tready);
  assign m_tvalid = out_valid;
  assign m_result = out_data;

  always_comb begin
    tap_next        = tap;
    known_next      = known;
    target_next     = target;
    state_next      = state;
    hcount_next     = hcount;
    store_pend_next = store_pend;
    sel_next        = sel;
    inc_next        = inc;
    dir_next        = dir;
    rej             = 1'b0;

    if (cfg.oe_clear && !known) begin
      tap_next   = '0;
      known_next = 1'b1;
    end

    if (q_pop) begin
      if (!q_head.is_set) begin
        case (state)
          SEQ_HOME_LOW: begin
            if (hcount < cfg.max_tap) begin
              sel_next    = 1'b0;
              dir_next    = 1'b0;
              inc_next    = 1'b0;
              hcount_next = hcount + TAP_BITS'(1);
              state_next  = SEQ_HOME_HIGH;
            end else begin
              sel_next   = 1'b1;
              tap_next   = '0;
              known_next = 1'b1;
              state_next = SEQ_STEP_LOW;
            end
          end
          SEQ_HOME_HIGH: begin
            inc_next   = 1'b1;
            state_next = SEQ_HOME_LOW;
          end
          SEQ_STEP_LOW: begin
            if (tap != target) begin
              sel_next   = 1'b0;
              dir_next   = (tap < target);
              inc_next   = 1'b0;
              state_next = SEQ_STEP_HIGH;
            end else if (store_pend) begin
              sel_next   = 1'b0;
              inc_next   = 1'b1;
              state_next = SEQ_STORE_END;
            end else begin
              state_next = SEQ_IDLE;
            end
          end
          SEQ_STEP_HIGH: begin
            inc_next   = 1'b1;
            state_next = SEQ_STEP_END;
          end
          SEQ_STEP_END: begin
            sel_next   = 1'b1;
            tap_next   = dir ? tap + TAP_BITS'(1) : tap - TAP_BITS'(1);
            state_next = SEQ_STEP_LOW;
          end
          SEQ_STORE_END: begin
            sel_next        = 1'b1;
            store_pend_next = 1'b0;
            state_next      = SEQ_IDLE;
          end
          default: state_next = SEQ_IDLE;   // idle tick: pins hold
        endcase
      end else if (state != SEQ_IDLE) begin
        rej = 1'b1;
      end else if (!cfg.output_enabled) begin
        // dummy mode: jump straight to the target
        tap_next    = q_head.target;
        target_next = q_head.target;
        known_next  = 1'b1;
      end else begin
        target_next     = q_head.target;
        store_pend_next = q_head.store;
        if (!known) begin
          sel_next    = 1'b0;
          dir_next    = 1'b0;
          inc_next    = 1'b1;
          hcount_next = '0;
          state_next  = SEQ_HOME_LOW;
        end else begin
          state_next = SEQ_STEP_LOW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap        <= '0;
      known      <= 1'b0;
      target     <= '0;
      state      <= SEQ_IDLE;
      hcount     <= '0;
      store_pend <= 1'b0;
      sel        <= 1'b1;
      inc        <= 1'b1;
      dir        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      tap        <= tap_next;
      known      <= known_next;
      target     <= target_next;
      state      <= state_next;
      hcount     <= hcount_next;
      store_pend <= store_pend_next;
      sel        <= sel_next;
      inc        <= inc_next;
      dir        <= dir_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.select_level    <= sel_next;
      out_data.increment_level <= inc_next;
      out_data.direction_level <= dir_next;
      out_data.tap_now         <= known_next ? tap_next : '0;
      out_data.tap_known       <= known_next;
      out_data.busy_res        <= (state_next != SEQ_IDLE);
      out_data.rejected        <= rej;
    end
  end

  // pins are parked (deselected, increment high) whenever no sequence runs
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_IDLE) |-> (sel && inc))
    else $error("pins not parked while idle");

  a_known_sticky: assert property (@(posedge clk) disable iff (rst)
    known |=> known)
    else $error("tap position lost after being known");

  a_step_needs_known: assert property (@(posedge clk) disable iff (rst)
    (state == SEQ_STEP_LOW || state == SEQ_STEP_HIGH || state == SEQ_STEP_END) |-> known)
    else $error("stepping with unknown position");

endmodule

### rtl/core/updown_digipot_tap_controller.sv
// Top level: config registers, front end, queue and sequencer.
//
// Drives a three-wire up/down digital potentiometer. Every input request on
// the s_ side yields exactly one result on the m_ side. s_tuser is the
// command: 0 is a tick (one pulse half-period), 1 is a set-tap request with
// target_tap and store_after in s_tdata. A result carries the three pin
// levels, the tracked tap, whether it is known, busy, and a reject flag for
// a set-tap request that arrived while a sequence ran.
// A result passes through a queue entry, then the result register, after its
// request is accepted; the block takes one request per cycle while m_tready
// stays high.
// A two-entry queue sits between decode and the sequencer, and the result
// register holds while m_tready is low; the queue keeps taking requests
// until it is full, then s_tready drops.
// Reset (rst, synchronous) parks the pins deselected with increment high,
// marks the position unknown, and loads output_enabled 1, max_tap 99.
// The first set-tap request while unknown with output enabled homes by pulsing down max_tap times.
// Registers (APB, byte address 0: output_enabled, 4: max_tap): the user must
// write them only while no request is in flight; the block does not enforce it.
module updown_digipot_tap_controller import udtc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // [0] command
  input  logic [15:0] s_tdata,   // [7:0] target_tap, [8] store_after
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] select_level, [1] increment_level, [2] direction_level,
  // [9:3] tap_now, [10] tap_known, [11] busy_res, [12] rejected
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                output_enabled;
  logic [TAP_BITS-1:0] max_tap;
  logic                wr_en;
  cfg_t                cfg;
  logic                q_ready, q_push, q_pop, q_valid;
  item_t               q_in, q_head;
  result_t             res;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enabled <= 1'b1;
      max_tap        <= TAP_BITS'(99);
    end else if (wr_en) begin
      case (paddr[2])
        REG_OUTPUT_ENABLED: output_enabled <= pwdata[0];
        REG_MAX_TAP:        max_tap        <= pwdata[TAP_BITS-1:0];
        default:            max_tap        <= max_tap;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OUTPUT_ENABLED: prdata = {31'b0, output_enabled};
      REG_MAX_TAP:        prdata = {{(32-TAP_BITS){1'b0}}, max_tap};
      default:            prdata = '0;
    endcase
  end

  assign cfg.output_enabled = output_enabled;
  assign cfg.max_tap        = max_tap;
  assign cfg.oe_clear       = wr_en && (paddr[2] == REG_OUTPUT_ENABLED) && !pwdata[0];

  udtc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .max_tap  (max_tap),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  udtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  udtc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (res)
  );

  assign m_tdata = {3'b0, res};

endmodule

### tb/updown_digipot_tap_controller_tb.sv
// Self-checking stream testbench for the up/down digipot tap controller.
module updown_digipot_tap_controller_tb;
  import udtc_pkg::*;

  // Tracks the sequencer and pins per accepted request, checks each result in order.
  class tap_scoreboard;
    bit                oe;
    bit [TAP_BITS-1:0] max_tap;
    bit [TAP_BITS-1:0] tap;
    bit                known;
    bit [TAP_BITS-1:0] goal;
    logic [2:0]        seq;
    bit [TAP_BITS-1:0] pulses;
    bit                store_pend;
    bit                sel, inc, dir;
    result_t           expected_q[$];
    int                mismatches, checked, requests, rejects;

    function new();
      oe = 1'b1;
      max_tap = 7'd99;
      tap = '0;
      known = 1'b0;
      goal = '0;
      seq = SEQ_IDLE;
      pulses = '0;
      store_pend = 1'b0;
      sel = 1'b1;
      inc = 1'b1;
      dir = 1'b0;
    endfunction

    function void write_reg(logic idx, bit [TAP_BITS-1:0] val);
      if (idx == REG_OUTPUT_ENABLED) begin
        oe = val[0];
        // dummy mode with no homing yet: position taken as tap 0
        if (!oe && !known) begin
          tap = '0;
          known = 1'b1;
        end
      end else begin
        max_tap = val;
      end
    endfunction

    function void note_request(logic cmd, logic [7:0] req, logic st);
      result_t           r;
      bit                rej;
      bit [TAP_BITS-1:0] clamped;
      rej = 1'b0;
      requests++;
      if (cmd == CMD_TICK) begin
        case (seq)
          SEQ_HOME_LOW: begin
            if (pulses < max_tap) begin
              sel = 1'b0; dir = 1'b0; inc = 1'b0;
              pulses = pulses + 1;
              seq = SEQ_HOME_HIGH;
            end else begin
              sel = 1'b1;
              tap = '0;
              known = 1'b1;
              seq = SEQ_STEP_LOW;
            end
          end
          SEQ_HOME_HIGH: begin
            inc = 1'b1;
            seq = SEQ_HOME_LOW;
          end
          SEQ_STEP_LOW: begin
            if (tap != goal) begin
              sel = 1'b0;
              dir = (tap < goal);
              inc = 1'b0;
              seq = SEQ_STEP_HIGH;
            end else if (store_pend) begin
              sel = 1'b0;
              inc = 1'b1;
              seq = SEQ_STORE_END;
            end else begin
              seq = SEQ_IDLE;
            end
          end
          SEQ_STEP_HIGH: begin
            inc = 1'b1;
            seq = SEQ_STEP_END;
          end
          SEQ_STEP_END: begin
            sel = 1'b1;
            tap = dir ? tap + 1 : tap - 1;
            seq = SEQ_STEP_LOW;
          end
          SEQ_STORE_END: begin
            sel = 1'b1;
            store_pend = 1'b0;
            seq = SEQ_IDLE;
          end
          default: seq = SEQ_IDLE;
        endcase
      end else if (seq != SEQ_IDLE) begin
        rej = 1'b1;
        rejects++;
      end else begin
        clamped = (req > {1'b0, max_tap}) ? max_tap : req[TAP_BITS-1:0];
        if (!oe) begin
          tap = clamped;
          goal = clamped;
          known = 1'b1;
        end else begin
          goal = clamped;
          store_pend = st;
          if (!known) begin
            sel = 1'b0; dir = 1'b0; inc = 1'b1;
            pulses = '0;
            seq = SEQ_HOME_LOW;
          end else begin
            seq = SEQ_STEP_LOW;
          end
        end
      end
      r.select_level    = sel;
      r.increment_level = inc;
      r.direction_level = dir;
      r.tap_now         = known ? tap : '0;
      r.tap_known       = known;
      r.busy_res        = (seq != SEQ_IDLE);
      r.rejected        = rej;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [15:0] data);
      result_t got, want;
      got = data[12:0];
      checked++;
      if (expected_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result %h with no request outstanding", data);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got !== want || data[15:13] !== 3'b000) begin
        if (mismatches < 10) begin
          $display("result %0d: exp sel=%b inc=%b dir=%b tap=%0d known=%b busy=%b rej=%b",
                   checked, want.select_level, want.increment_level, want.direction_level,
                   want.tap_now, want.tap_known, want.busy_res, want.rejected);
          $display("  got sel=%b inc=%b dir=%b tap=%0d known=%b busy=%b rej=%b pad=%b",
                   got.select_level, got.increment_level, got.direction_level,
                   got.tap_now, got.tap_known, got.busy_res, got.rejected, data[15:13]);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic        s_tuser;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tap_scoreboard sb = new();
  bit            no_gaps = 1'b0;
  int            phases;

  updown_digipot_tap_controller DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted results, stall now and then
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata);
    m_tready <= no_gaps || ($urandom_range(0, 99) >= 8);
  end

  task automatic send_request(input logic cmd, input logic [7:0] tgt, input logic st);
    if (!no_gaps && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {7'b0, st, tgt};
    do @(posedge clk); while (!s_tready);
    sb.note_request(cmd, tgt, st);
  endtask

  // ticks until the sequencer is idle; busy_pct mixes in requests that must be dropped
  task automatic run_until_idle(input int busy_pct);
    while (sb.seq != SEQ_IDLE) begin
      if ($urandom_range(0, 99) < busy_pct)
        send_request(CMD_SET, $urandom_range(0, 255), $urandom_range(0, 1));
      else
        send_request(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [TAP_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {25'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    #(12 * 300000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0]          tgt;
    logic [TAP_BITS-1:0] mt;
    logic                en;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = CMD_TICK;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick, homing with max_tap cut short mid-way, busy drop
    send_request(CMD_TICK, 8'hFF, 1'b1);
    drain();
    apb_write(REG_MAX_TAP, 7'd3);
    send_request(CMD_SET, 8'd1, 1'b0);
    repeat (3) send_request(CMD_TICK, 8'h00, 1'b0);
    drain();
    apb_write(REG_MAX_TAP, 7'd1);
    send_request(CMD_SET, 8'hFF, 1'b1);
    run_until_idle(0);
    // step down then store
    send_request(CMD_SET, 8'd0, 1'b1);
    run_until_idle(0);
    drain();
    // dummy mode: tap set at once, pins hold
    apb_write(REG_OUTPUT_ENABLED, 7'd0);
    send_request(CMD_SET, 8'd200, 1'b1);
    drain();
    apb_write(REG_MAX_TAP, 7'd0);
    send_request(CMD_SET, 8'd5, 1'b0);
    drain();
    apb_write(REG_OUTPUT_ENABLED, 7'd1);
    send_request(CMD_SET, 8'd9, 1'b1);
    run_until_idle(0);
    drain();
    apb_write(REG_MAX_TAP, 7'd127);
    apb_write(REG_OUTPUT_ENABLED, 7'd0);
    send_request(CMD_SET, 8'd255, 1'b0);
    drain();

    // random phases, each with its own register setting
    phases = 0;
    while (sb.requests < 1830) begin
      no_gaps = (phases >= 4 && phases < 8);
      drain();
      case ($urandom_range(0, 9))
        0: mt = 7'd0;
        1: mt = 7'd1;
        2: mt = 7'd127;
        3, 4: mt = 7'($urandom_range(1, 127));
        default: mt = 7'($urandom_range(2, 12));
      endcase
      en = ($urandom_range(0, 4) != 0);
      apb_write(REG_MAX_TAP, mt);
      apb_write(REG_OUTPUT_ENABLED, {6'b0, en});
      phases++;
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(0, 99) < 80) begin
          case ($urandom_range(0, 3))
            0, 1: tgt = 8'(sb.tap + $urandom_range(0, 12) - 6);
            2: tgt = 8'($urandom_range(0, 255));
            default: begin
              case ($urandom_range(0, 3))
                0: tgt = 8'd0;
                1: tgt = 8'd255;
                2: tgt = {1'b0, sb.max_tap};
                default: tgt = {1'b0, sb.max_tap} + 8'd1;
              endcase
            end
          endcase
          send_request(CMD_SET, tgt, $urandom_range(0, 1));
          run_until_idle($urandom_range(0, 1) ? 0 : 4);
          repeat ($urandom_range(0, 2))
            send_request(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 1));
        end else begin
          repeat ($urandom_range(1, 4))
            send_request($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 1));
        end
      end
    end

    no_gaps = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    $display("covered %0d requests (%0d dropped while busy), %0d results checked",
             sb.requests, sb.rejects, sb.checked);
    $display("%0d random register settings plus homing, dummy mode and max_tap 0/1/127",
             phases);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
